// File: hdl/fnpd_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fnpd_pkg
// shared widths, reset values and register indexes of the peak detector
// -----------------------------------------------------------------------------
package fnpd_pkg;

   localparam int ROW_W   = 16;   // row index and num_rows width
   localparam int PCOL_W  = 10;   // reported column width
   localparam int NCOLS_W = 11;   // num_cols register width
   localparam int CSR_W   = 16;   // widest register

   localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 11'd1024;
   localparam logic [ROW_W-1:0]   NUM_ROWS_RST = 16'd1024;

   typedef enum logic [0:0] {
      CSR_NUM_COLS = 1'b0,
      CSR_NUM_ROWS = 1'b1
   } csr_index_type;

endpackage

// File: hdl/fnpd_req_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fnpd_req_if
// sample channel: valid/ready handshake carrying one grid element
// -----------------------------------------------------------------------------
interface fnpd_req_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// File: hdl/fnpd_rsp_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fnpd_rsp_if
// peak channel: valid/ready handshake carrying value and position of a peak
// -----------------------------------------------------------------------------
interface fnpd_rsp_if #(
   parameter int DATA_WIDTH = 16
);
   import fnpd_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] peak_value;
   logic [ROW_W-1:0]             peak_row;
   logic [PCOL_W-1:0]            peak_col;

   modport source (output valid, output peak_value, output peak_row, output peak_col,
                   input ready);
   modport sink   (input valid, input peak_value, input peak_row, input peak_col,
                   output ready);
endinterface

// File: hdl/fnpd_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fnpd_ram
// simple dual port ram, one write and one registered read per cycle
// -----------------------------------------------------------------------------
module fnpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/four_neighbour_peak_detector_unit.sv
`timescale 1ns / 1ps
// a peak found on an accepted sample goes through the compare stage to the output register on rsp
// throughput: one sample per cycle, set by the single line buffer ram (one read and
//   one write per cycle); a waiting result holds the input only once a second peak queues
// reset: synchronous, clears counters, registers to 1024 x 1024, pipeline and output valid
// the line buffer ram is not cleared; entries are always written before they are tested
// -----------------------------------------------------------------------------
// four_neighbour_peak_detector_unit
// streaming 4-neighbour local maximum detector over a raster-order grid
// -----------------------------------------------------------------------------
module four_neighbour_peak_detector_unit #(
   parameter int MAX_COLS   = 1024,
   parameter int DATA_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   fnpd_req_if.sink               req_if,
   fnpd_rsp_if.source             rsp_if,
   input  logic                   csr_write_en,
   input  fnpd_pkg::csr_index_type csr_index,
   input  logic [fnpd_pkg::CSR_W-1:0] csr_wdata
);
   import fnpd_pkg::*;

   localparam int CW    = $clog2(MAX_COLS);   // column index width
   localparam int CNT_W = CW + 1;             // holds the column count itself
   localparam int DW    = DATA_WIDTH;

   // line buffer entry per column: {row r-1 value, row r-2 value}
   typedef logic [2*DW-1:0] entry_type;

   // configuration
   logic [NCOLS_W-1:0] num_cols_ff;
   logic [ROW_W-1:0]   num_rows_ff;
   logic [CNT_W-1:0]   cols_eff;
   logic [ROW_W-1:0]   rows_eff;

   // raster position of the next sample
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_inc;
   logic [ROW_W:0]   row_inc;
   logic             last_col;
   logic [CW-1:0]    next_col;

   // handshake
   logic req_fire;
   logic s1_go;

   // ram ports
   logic [CW-1:0] rd_addr;
   entry_type     rd_data;
   entry_type     rd_eff;
   entry_type     wr_data;

   // read-ahead: entry of the column the next sample lands in
   entry_type ahead_ff;
   entry_type cur_entry;
   logic      fwd_ff;
   entry_type fwd_data_ff;
   logic signed [DW-1:0] prev_mid_ff;

   // compare stage
   logic                 s1_valid_ff;
   logic                 s1_test_ff;
   logic signed [DW-1:0] s1_sample_ff;
   logic signed [DW-1:0] s1_mid_ff;
   logic signed [DW-1:0] s1_up_ff;
   logic signed [DW-1:0] s1_left_ff;
   logic [ROW_W-1:0]     s1_row_ff;
   logic [CW-1:0]        s1_col_ff;
   logic signed [DW-1:0] s1_right;
   logic                 s1_hit;

   // output register
   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_value_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [PCOL_W-1:0]    rsp_col_ff;

   // ---------------------------------------------------------------------------
   // effective grid size: zero acts as one, columns clamp to the buffer size
   // ---------------------------------------------------------------------------
   always_comb begin
      if (num_cols_ff == '0) begin
         cols_eff = CNT_W'(1);
      end else if (32'(num_cols_ff) > MAX_COLS) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = CNT_W'(num_cols_ff);
      end
      rows_eff = (num_rows_ff == '0) ? ROW_W'(1) : num_rows_ff;
   end

   // ---------------------------------------------------------------------------
   // raster counters
   // ---------------------------------------------------------------------------
   assign col_inc  = {1'b0, col_ff} + CNT_W'(1);
   assign row_inc  = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign last_col = (col_inc >= cols_eff);
   assign next_col = last_col ? '0 : col_inc[CW-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write_en) begin
         // any register write restarts the frame
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         col_in = next_col;
         if (last_col) begin
            row_in = (row_inc >= {1'b0, rows_eff}) ? '0 : row_inc[ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= NUM_COLS_RST;
         num_rows_ff <= NUM_ROWS_RST;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_NUM_COLS: num_cols_ff <= csr_wdata[NCOLS_W-1:0];
               CSR_NUM_ROWS: num_rows_ff <= csr_wdata[ROW_W-1:0];
               default:      ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // line buffer: on each sample write its column back shifted by one row and
   // fetch the next column through the registered read, so the right neighbour
   // is ready when the sample reaches the compare stage
   assign req_fire = req_if.valid && req_if.ready;
   assign rd_addr  = next_col;

   // a single-column grid reads the entry written in the same cycle
   assign rd_eff    = fwd_ff ? fwd_data_ff : rd_data;
   assign cur_entry = s1_valid_ff ? rd_eff : ahead_ff;
   assign wr_data   = {req_if.sample, cur_entry[2*DW-1:DW]};

   fnpd_ram #(
      .WIDTH (2*DW),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (col_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------------
   // compare stage: element above the new sample against its four neighbours
   // ---------------------------------------------------------------------------
   assign s1_right = rd_eff[2*DW-1:DW];
   assign s1_hit   = s1_test_ff &&
                     (s1_mid_ff > s1_left_ff) && (s1_mid_ff > s1_right) &&
                     (s1_mid_ff > s1_up_ff)   && (s1_mid_ff > s1_sample_ff);

   // a hit waits while the output register is still occupied
   assign s1_go       = s1_valid_ff && (!s1_hit || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         ahead_ff <= rd_eff;
      end
      if (req_fire) begin
         fwd_ff       <= (next_col == col_ff);
         fwd_data_ff  <= wr_data;
         prev_mid_ff  <= cur_entry[2*DW-1:DW];
         s1_sample_ff <= req_if.sample;
         s1_mid_ff    <= cur_entry[2*DW-1:DW];
         s1_up_ff     <= cur_entry[DW-1:0];
         s1_left_ff   <= prev_mid_ff;
         s1_row_ff    <= row_ff - ROW_W'(1);
         s1_col_ff    <= col_ff;
         // interior only: row 2 onward, column away from both borders
         s1_test_ff   <= (row_ff >= ROW_W'(2)) && (col_ff != '0) && !last_col;
      end
   end

   // ---------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_hit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_hit) begin
         rsp_value_ff <= s1_mid_ff;
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= PCOL_W'(s1_col_ff);
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.peak_value = rsp_value_ff;
   assign rsp_if.peak_row   = rsp_row_ff;
   assign rsp_if.peak_col   = rsp_col_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < cols_eff)
      else $error("column counter beyond effective column count");

   a_peak_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0) && (rsp_col_ff != '0))
      else $error("peak reported on a border element");

   a_fire_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted sample did not reach compare stage");

   a_stall_keeps_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> s1_valid_ff && $stable(rd_data))
      else $error("right neighbour lost while compare stage stalled");
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// streams signed grids through the four-neighbour peak detector under several
// grid sizes and handshake loads; a per-sample predictor tracks the line
// buffers and counters, and every peak leaving the block is checked in order
// -----------------------------------------------------------------------------
module tb;
   import fnpd_pkg::*;

   localparam int MAX_COLS = 1024;
   localparam int DATA_W   = 16;
   localparam int SETTLE   = 8;    // wait after the bench drains, before a register write

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [ROW_W-1:0]         row;
      logic [PCOL_W-1:0]        col;
   } peak_type;

   logic          clock;
   logic          reset;
   logic          csr_write_en;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_wdata;

   fnpd_req_if #(.DATA_WIDTH(DATA_W)) req_if ();
   fnpd_rsp_if #(.DATA_WIDTH(DATA_W)) rsp_if ();

   four_neighbour_peak_detector_unit #(
      .MAX_COLS  (MAX_COLS),
      .DATA_WIDTH(DATA_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // samples waiting to be sent, peaks waiting to come out
   logic signed [DATA_W-1:0] sample_queue[$];
   peak_type                 peak_queue[$];

   // predictor state
   logic [NCOLS_W-1:0]       cfg_cols;
   logic [ROW_W-1:0]         cfg_rows;
   logic signed [DATA_W-1:0] line_buf [0:2*MAX_COLS-1];
   int                       col_pos;
   int                       row_pos;

   idle_mode_type idle_mode;
   bit            rsp_hold;
   bit            sample_taken;
   int            mismatch_count;

   int col_choices[12] = '{3, 3, 4, 4, 5, 6, 8, 12, 33, 2, 1, 0};
   int row_choices[10] = '{3, 4, 4, 5, 7, 9, 2, 1, 0, 65535};

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 70;
         IDLE_BOTH:   return $urandom_range(0, 99) < 26;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 70;
         IDLE_BOTH:     return $urandom_range(0, 99) < 26;
         default:       return 1'b0;
      endcase
   endfunction

   // one sample into the line buffers; the element above it may be a peak
   function automatic void track_grid_sample(input logic signed [DATA_W-1:0] smp);
      int cols;
      int rows;
      int c;
      int r;
      int bank_now;
      int bank_prev;
      logic signed [DATA_W-1:0] mid;
      cols = (cfg_cols == 0) ? 1 : ((cfg_cols > MAX_COLS) ? MAX_COLS : int'(cfg_cols));
      rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
      c = col_pos;
      r = row_pos;
      if (c >= cols) c = 0;
      bank_now  = (r % 2) * MAX_COLS;
      bank_prev = ((r + 1) % 2) * MAX_COLS;
      if (r >= 2 && c >= 1 && c + 1 < cols) begin
         mid = line_buf[bank_prev + c];
         if (mid > line_buf[bank_prev + c - 1] && mid > line_buf[bank_prev + c + 1] &&
             mid > line_buf[bank_now + c] && mid > smp)
            peak_queue.push_back('{mid, ROW_W'(r - 1), PCOL_W'(c)});
      end
      line_buf[bank_now + c] = smp;
      if (c + 1 >= cols) begin
         col_pos = 0;
         row_pos = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // predictor update and peak check
   always @(posedge clock) begin
      peak_type want;
      sample_taken = !reset && req_if.valid && req_if.ready;
      if (reset) begin
         cfg_cols = NUM_COLS_RST;
         cfg_rows = NUM_ROWS_RST;
         col_pos  = 0;
         row_pos  = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (peak_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected peak value %0d row %0d col %0d",
                                         rsp_if.peak_value, rsp_if.peak_row, rsp_if.peak_col));
            end else begin
               want = peak_queue.pop_front();
               if (rsp_if.peak_value !== want.value)
                  report_mismatch($sformatf("peak_value %0d, expected %0d",
                                            rsp_if.peak_value, want.value));
               if (rsp_if.peak_row !== want.row)
                  report_mismatch($sformatf("peak_row %0d, expected %0d",
                                            rsp_if.peak_row, want.row));
               if (rsp_if.peak_col !== want.col)
                  report_mismatch($sformatf("peak_col %0d, expected %0d",
                                            rsp_if.peak_col, want.col));
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_NUM_COLS: cfg_cols = csr_wdata[NCOLS_W-1:0];
               CSR_NUM_ROWS: cfg_rows = csr_wdata[ROW_W-1:0];
               default: ;
            endcase
            // any write restarts the frame
            col_pos = 0;
            row_pos = 0;
         end
         if (sample_taken) begin
            sample_queue.pop_front();
            track_grid_sample(req_if.sample);
         end
      end
   end

   // sample driver: a held item stays put until taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid  <= 1'b0;
         req_if.sample <= '0;
      end else if (!req_if.valid || sample_taken) begin
         if (sample_queue.size() > 0 && !sender_idles()) begin
            req_if.valid  <= 1'b1;
            req_if.sample <= sample_queue[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // peak receiver
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else       rsp_if.ready <= !rsp_hold && !receiver_stalls();
   end

   function automatic logic signed [DATA_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:          return 16'sh8000;
         1:          return 16'sh7FFF;
         2, 3, 4, 5: return $signed(DATA_W'($urandom_range(0, 8)) - DATA_W'(4));
         default:    return $signed(DATA_W'($urandom));
      endcase
   endfunction

   // everything sent and every peak seen
   task automatic wait_drained();
      while (sample_queue.size() != 0 || peak_queue.size() != 0 || req_if.valid)
         @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic reconfigure(input bit set_cols, input logic [CSR_W-1:0] cols_val,
                              input bit set_rows, input logic [CSR_W-1:0] rows_val);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (set_rows) write_csr(CSR_NUM_ROWS, rows_val);
      if (set_cols) write_csr(CSR_NUM_COLS, cols_val);
   endtask

   task automatic push_grid(input logic signed [DATA_W-1:0] vals[]);
      foreach (vals[i]) sample_queue.push_back(vals[i]);
   endtask

   // wide rows: small noise with full-scale values at both interior ends of row 1
   // and one full-scale value on the top border that must never be reported
   task automatic queue_wide_frame(input int cols, input int n);
      int row;
      int col;
      logic signed [DATA_W-1:0] v;
      for (int i = 0; i < n; i++) begin
         row = i / cols;
         col = i % cols;
         v = $signed(DATA_W'($urandom_range(0, 8)) - DATA_W'(4));
         if ((row == 1 && (col == 1 || col == cols - 2)) || (row == 0 && col == 5))
            v = 16'sh7FFF;
         sample_queue.push_back(v);
      end
   endtask

   initial begin
      int random_sent;
      int phase;
      int n;
      int cols;
      bit pause_mid;
      clock          = 1'b0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_NUM_COLS;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.sample  = '0;
      rsp_if.ready   = 1'b0;
      idle_mode      = IDLE_NONE;
      rsp_hold       = 1'b0;
      mismatch_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry 1024 x 1024: part of the top row, nothing may be reported
      idle_mode = IDLE_BOTH;
      queue_wide_frame(MAX_COLS, 20);

      // 3x3 with a single full-scale peak; upper wdata bits of num_cols ignored
      reconfigure(1'b1, 16'hF803, 1'b1, 16'd3);
      idle_mode = IDLE_NONE;
      push_grid('{16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh7FFF, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000});
      // next frame after the wrap: center ties the element below, so no peak
      push_grid('{16'sd0, -16'sd2, 16'sd0,
                  -16'sd2, -16'sd1, -16'sd2,
                  16'sd0, -16'sd1, 16'sd0});
      // zero rows acts as one row
      reconfigure(1'b0, '0, 1'b1, 16'd0);
      push_grid('{16'sd5, 16'sd9, 16'sd1});
      // zero columns acts as one column
      reconfigure(1'b1, 16'd0, 1'b1, 16'd4);
      push_grid('{16'sd1, 16'sd7, 16'sd2, 16'sd3});

      // random grids, frames often cut short by the next write
      random_sent = 0;
      phase = 0;
      while (random_sent < 440) begin
         reconfigure($urandom_range(0, 3) != 0,
                     CSR_W'(col_choices[$urandom_range(0, 11)]),
                     $urandom_range(0, 3) != 0,
                     CSR_W'(row_choices[$urandom_range(0, 9)]));
         idle_mode = idle_mode_type'(phase % 4);
         n = $urandom_range(15, 90);
         pause_mid = (phase % 3 == 2);
         for (int i = 0; i < n; i++) begin
            // sender waits for every outstanding peak halfway through
            if (pause_mid && i == n / 2) wait_drained();
            sample_queue.push_back(random_sample());
         end
         random_sent += n;
         phase++;

         if (phase == 4) begin
            // receiver holds off while a checkerboard floods the output with peaks
            reconfigure(1'b1, 16'd6, 1'b1, 16'hFFFF);
            idle_mode = IDLE_NONE;
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (400) @(posedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
            for (int i = 0; i < 240; i++)
               sample_queue.push_back((((i / 6) + (i % 6)) % 2 == 1) ?
                                      $signed(DATA_W'(100 + $urandom_range(0, 50))) :
                                      -16'sd100);
            random_sent += 240;
         end
      end

      // oversized column count clamps to the maximum: part of the top row
      reconfigure(1'b1, 16'hFFFF, 1'b1, 16'd3);
      idle_mode = IDLE_SENDER;
      queue_wide_frame(MAX_COLS, 20);

      wait_drained();
      idle_mode = IDLE_NONE;
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && peak_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
